FILE: rtl/ascii_to_morse_keying_defines.svh
// Assertion macros shared by the Morse keying RTL.
// No dependencies; included by files that carry assertions.
`ifndef ASCII_TO_MORSE_KEYING_DEFINES_SVH
`define ASCII_TO_MORSE_KEYING_DEFINES_SVH

// same-cycle implication
`define A2MK_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define A2MK_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/a2mk_pkg.sv
// Types, constants and the Morse pattern table for the keying block.
// No dependencies.
package a2mk_pkg;

  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned UNIT_W   = 11;
  localparam int unsigned UNITS_W  = 3;
  localparam int unsigned MS_W     = 13;
  localparam int unsigned PAT_W    = 7;
  localparam int unsigned PLEN_W   = 3;

  localparam logic [CHAR_W-1:0]  SPACE_CODE    = 8'd32;
  localparam logic [UNIT_W-1:0]  UNIT_MS_RESET = 11'd60;

  localparam logic [UNITS_W-1:0] DOT_UNITS   = 3'd1;
  localparam logic [UNITS_W-1:0] DASH_UNITS  = 3'd3;
  localparam logic [UNITS_W-1:0] IGAP_UNITS  = 3'd1;
  localparam logic [UNITS_W-1:0] SPACE_UNITS = 3'd4;
  localparam logic [UNITS_W-1:0] END_UNITS   = 3'd2;

  typedef struct packed {
    logic                key_on;
    logic [UNITS_W-1:0]  units;
    logic                last;
  } seg_t;

  typedef struct packed {
    logic [PLEN_W-1:0] len;
    logic [PAT_W-1:0]  bits;   // first symbol in MSB, 1 = dash
  } pat_t;

  function automatic pat_t morse_lookup(logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] f;
    pat_t p;
    f = (c >= 8'd97 && c <= 8'd122) ? c - 8'd32 : c;
    case (f)
      8'd33: p = '{3'd6, 7'b1010110};
      8'd34: p = '{3'd6, 7'b0100100};
      8'd36: p = '{3'd7, 7'b0001001};
      8'd38: p = '{3'd5, 7'b0100000};
      8'd39: p = '{3'd6, 7'b0111100};
      8'd40: p = '{3'd5, 7'b1011000};
      8'd41: p = '{3'd6, 7'b1011010};
      8'd43: p = '{3'd5, 7'b0101000};
      8'd44: p = '{3'd6, 7'b1100110};
      8'd45: p = '{3'd6, 7'b1000010};
      8'd46: p = '{3'd6, 7'b0101010};
      8'd47: p = '{3'd5, 7'b1001000};
      8'd48: p = '{3'd5, 7'b1111100};
      8'd49: p = '{3'd5, 7'b0111100};
      8'd50: p = '{3'd5, 7'b0011100};
      8'd51: p = '{3'd5, 7'b0001100};
      8'd52: p = '{3'd5, 7'b0000100};
      8'd53: p = '{3'd5, 7'b0000000};
      8'd54: p = '{3'd5, 7'b1000000};
      8'd55: p = '{3'd5, 7'b1100000};
      8'd56: p = '{3'd5, 7'b1110000};
      8'd57: p = '{3'd5, 7'b1111000};
      8'd58: p = '{3'd6, 7'b1110000};
      8'd59: p = '{3'd6, 7'b1010100};
      8'd61: p = '{3'd5, 7'b1000100};
      8'd63: p = '{3'd6, 7'b0011000};
      8'd64: p = '{3'd6, 7'b0110100};
      8'd65: p = '{3'd2, 7'b0100000};
      8'd66: p = '{3'd4, 7'b1000000};
      8'd67: p = '{3'd4, 7'b1010000};
      8'd68: p = '{3'd3, 7'b1000000};
      8'd69: p = '{3'd1, 7'b0000000};
      8'd70: p = '{3'd4, 7'b0010000};
      8'd71: p = '{3'd3, 7'b1100000};
      8'd72: p = '{3'd4, 7'b0000000};
      8'd73: p = '{3'd2, 7'b0000000};
      8'd74: p = '{3'd4, 7'b0111000};
      8'd75: p = '{3'd3, 7'b1010000};
      8'd76: p = '{3'd4, 7'b0100000};
      8'd77: p = '{3'd2, 7'b1100000};
      8'd78: p = '{3'd2, 7'b1000000};
      8'd79: p = '{3'd3, 7'b1110000};
      8'd80: p = '{3'd4, 7'b0110000};
      8'd81: p = '{3'd4, 7'b1101000};
      8'd82: p = '{3'd3, 7'b0100000};
      8'd83: p = '{3'd3, 7'b0000000};
      8'd84: p = '{3'd1, 7'b1000000};
      8'd85: p = '{3'd3, 7'b0010000};
      8'd86: p = '{3'd4, 7'b0001000};
      8'd87: p = '{3'd3, 7'b0110000};
      8'd88: p = '{3'd4, 7'b1001000};
      8'd89: p = '{3'd4, 7'b1011000};
      8'd90: p = '{3'd4, 7'b1100000};
      8'd95: p = '{3'd6, 7'b0011010};
      default: p = '{3'd0, 7'b0000000};
    endcase
    return p;
  endfunction

endpackage

FILE: rtl/a2mk_seq.sv
// Segment sequencer: loads a character's pattern into a shift register and
// steps out one key segment per take. Depends on a2mk_pkg.
module a2mk_seq
  import a2mk_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  logic [CHAR_W-1:0] char_code,
  input  logic              take,
  output logic              idle,
  output logic              seg_valid,
  output seg_t              seg
);

  typedef enum logic [2:0] {S_IDLE, S_SYM, S_IGAP, S_SPACE, S_END} state_t;

  state_t             state;
  logic [PAT_W-1:0]   pat;
  logic [PLEN_W-1:0]  cnt;
  pat_t               lk;

  assign lk = morse_lookup(char_code);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pat   <= '0;
      cnt   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (load) begin
            pat <= lk.bits;
            cnt <= lk.len;
            if (lk.len != '0) begin
              state <= S_SYM;
            end else if (char_code == SPACE_CODE) begin
              state <= S_SPACE;
            end else begin
              state <= S_END;
            end
          end
        end
        S_SYM: begin
          if (take) state <= S_IGAP;
        end
        S_IGAP: begin
          if (take) begin
            pat <= {pat[PAT_W-2:0], 1'b0};
            cnt <= cnt - PLEN_W'(1);
            state <= (cnt == PLEN_W'(1)) ? S_END : S_SYM;
          end
        end
        S_SPACE: begin
          if (take) state <= S_END;
        end
        S_END: begin
          if (take) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    seg = '{key_on: 1'b0, units: END_UNITS, last: 1'b0};
    case (state)
      S_SYM:   seg = '{key_on: 1'b1, units: pat[PAT_W-1] ? DASH_UNITS : DOT_UNITS,
                       last: 1'b0};
      S_IGAP:  seg = '{key_on: 1'b0, units: IGAP_UNITS, last: 1'b0};
      S_SPACE: seg = '{key_on: 1'b0, units: SPACE_UNITS, last: 1'b0};
      S_END:   seg = '{key_on: 1'b0, units: END_UNITS, last: 1'b1};
      default: seg = '{key_on: 1'b0, units: END_UNITS, last: 1'b0};
    endcase
  end

  assign idle      = (state == S_IDLE);
  assign seg_valid = !idle;

endmodule

FILE: rtl/a2mk_out.sv
// Output register: scales a segment's unit count to milliseconds by
// shift-add and holds the beat until the receiver takes it. Depends on a2mk_pkg.
module a2mk_out
  import a2mk_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic [UNIT_W-1:0] unit_ms,
  input  logic              seg_valid,
  input  seg_t              seg,
  output logic              take,
  input  logic              out_ready,
  output logic              out_valid,
  output logic              key_on,
  output logic [UNITS_W-1:0] length_units,
  output logic [MS_W-1:0]   length_ms,
  output logic              last_segment
);

  logic [MS_W-1:0] ms_next;

  always_comb begin
    ms_next = '0;
    if (seg.units[0]) ms_next = ms_next + MS_W'(unit_ms);
    if (seg.units[1]) ms_next = ms_next + MS_W'({unit_ms, 1'b0});
    if (seg.units[2]) ms_next = ms_next + MS_W'({unit_ms, 2'b00});
  end

  assign take = seg_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      key_on       <= seg.key_on;
      length_units <= seg.units;
      length_ms    <= ms_next;
      last_segment <= seg.last;
    end
  end

endmodule

FILE: rtl/ascii_to_morse_keying.sv
// Top level of the ASCII to Morse keying block.
// Depends on a2mk_pkg, a2mk_seq, a2mk_out and ascii_to_morse_keying_defines.svh.
//
// Usage:
//   s_* channel takes one ASCII character per beat (s_tdata[7:0]).
//   m_* channel gives key segments: m_tdata[0] key level, [3:1] length in
//   dot units, [16:4] length in ms; m_tlast marks the closing gap.
//   cfg_* channel writes the dot length in ms (always ready); write it only
//   while no character is in flight.
// Timing:
//   A character yields 1 to 15 segments, one per cycle from the pattern
//   shift register unless m_tready stalls; it holds the block until its
//   closing gap is taken, and its first segment passes the sequencer state
//   register, then the output register. The next character is taken the
//   cycle after the closing gap enters the output register.
// Stall: m_tready low holds the output beat and freezes the sequencer;
//   s_tready stays low until the current character is fully queued.
// Reset: rst (sync, high) drops all pending segments, returns to idle and
//   sets the dot length to 60 ms.
`include "ascii_to_morse_keying_defines.svh"
module ascii_to_morse_keying
  import a2mk_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // char_code[7:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // key_on, length_units[2:0], length_ms[12:0], zero pad
  output logic        m_tlast,   // last_segment
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [10:0] cfg_data   // unit_ms
);

  logic [UNIT_W-1:0]  unit_ms;
  logic               idle;
  logic               seg_valid;
  logic               take;
  seg_t               seg;
  logic               key_on;
  logic [UNITS_W-1:0] length_units;
  logic [MS_W-1:0]    length_ms;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      unit_ms <= UNIT_MS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unit_ms <= cfg_data;
    end
  end

  assign s_tready = idle;

  a2mk_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .load      (s_tvalid && s_tready),
    .char_code (s_tdata),
    .take      (take),
    .idle      (idle),
    .seg_valid (seg_valid),
    .seg       (seg)
  );

  a2mk_out u_out (
    .clk          (clk),
    .rst          (rst),
    .unit_ms      (unit_ms),
    .seg_valid    (seg_valid),
    .seg          (seg),
    .take         (take),
    .out_ready    (m_tready),
    .out_valid    (m_tvalid),
    .key_on       (key_on),
    .length_units (length_units),
    .length_ms    (length_ms),
    .last_segment (m_tlast)
  );

  assign m_tdata = {7'b0, length_ms, length_units, key_on};

  `A2MK_ASSERT_NEXT(a_busy_after_load, clk, rst, s_tvalid && s_tready, !s_tready,
    "input taken while a character is still being sequenced")
  `A2MK_ASSERT_NOW(a_last_is_gap, clk, rst, m_tvalid && m_tlast,
    !key_on && length_units == END_UNITS, "closing beat is not the end gap")
  `A2MK_ASSERT_NOW(a_mark_units, clk, rst, m_tvalid && key_on,
    length_units == DOT_UNITS || length_units == DASH_UNITS,
    "key-down beat is neither dot nor dash")

endmodule
